// ===== src/brun_pkg.sv =====
package brun_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 11;
  localparam int CFG_W  = 8;
  localparam int BYTE_W = 8;
  localparam int SEL_W  = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_TEST  = 2'd1,
    FUNC_SCAN  = 2'd2,
    FUNC_WRITE = 2'd3
  } func_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic sweep_all;
    logic scan_rd;
    logic bit_rd;
    logic bit_wr;
    logic test_latch;
    logic result;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic scan_fin;
    logic reject;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/brun_if.sv =====
interface brun_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [brun_pkg::FUNC_W-1:0] func;
  logic [brun_pkg::IDX_W-1:0]  bit_index;
  logic [brun_pkg::LEN_W-1:0]  run_length;
  logic                        bit_value;

  modport source (output valid, func, bit_index, run_length, bit_value, input ready);
  modport sink (input valid, func, bit_index, run_length, bit_value, output ready);
endinterface

interface brun_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [brun_pkg::IDX_W-1:0] start_index;
  logic                       bit_state;

  modport source (output valid, found, start_index, bit_state, input ready);
  modport sink (input valid, found, start_index, bit_state, output ready);
endinterface

// ===== src/brun_ram.sv =====
module brun_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/brun_ctrl.sv =====
module brun_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [brun_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  brun_pkg::dp_sts_t           sts,
  output brun_pkg::ctl_cmd_t          ctl
);

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CLEAR    = 9'b000000100,
    S_TEST_RD  = 9'b000001000,
    S_TEST_LAT = 9'b000010000,
    S_SCAN     = 9'b000100000,
    S_WR_RD    = 9'b001000000,
    S_WR_WR    = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_INIT: begin
        ctl.sweep     = 1'b1;
        ctl.sweep_all = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          case (brun_pkg::func_t'(in_func))
            brun_pkg::FUNC_CLEAR: state_next = S_CLEAR;
            brun_pkg::FUNC_TEST:  state_next = S_TEST_RD;
            brun_pkg::FUNC_SCAN:  state_next = S_SCAN;
            default:              state_next = S_WR_RD;
          endcase
        end
      end
      S_CLEAR: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_TEST_RD: begin
        ctl.bit_rd = 1'b1;
        state_next = S_TEST_LAT;
      end
      S_TEST_LAT: begin
        ctl.test_latch = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        if (sts.reject || sts.scan_fin) begin
          state_next = S_DONE;
        end else begin
          ctl.scan_rd = 1'b1;
        end
      end
      S_WR_RD: begin
        ctl.bit_rd = 1'b1;
        state_next = S_WR_WR;
      end
      S_WR_WR: begin
        ctl.bit_wr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ===== src/brun_dp.sv =====
module brun_dp #(
  parameter int MAX_BYTES = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [brun_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [brun_pkg::IDX_W-1:0]  in_bit_index,
  input  logic [brun_pkg::LEN_W-1:0]  in_run_length,
  input  logic                        in_bit_value,
  input  brun_pkg::ctl_cmd_t          ctl,
  output brun_pkg::dp_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [brun_pkg::IDX_W-1:0]  out_start_index,
  output logic                        out_bit_state
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int PW = AW + 1;
  localparam int HW = AW + brun_pkg::SEL_W;
  localparam logic [PW-1:0] ALL_LAST = PW'(MAX_BYTES - 1);

  logic [brun_pkg::CFG_W-1:0]  bytes_in_use;
  logic [brun_pkg::IDX_W-1:0]  idx_r;
  logic [brun_pkg::LEN_W-1:0]  len_r;
  logic                        val_r;
  logic [PW-1:0]               ptr;
  logic [PW-1:0]               last;
  logic                        reject;
  logic                        proc_valid;
  logic [AW-1:0]               proc_addr;
  logic [brun_pkg::LEN_W-1:0]  count;
  logic [brun_pkg::LEN_W-1:0]  count_next;
  logic                        hit;
  logic [brun_pkg::SEL_W-1:0]  hit_bit;
  logic [HW-1:0]               hit_pos;
  logic                        scan_fin;
  logic                        found_r;
  logic                        state_r;
  logic                        idx_out;
  logic [AW-1:0]               idx_addr;
  logic [brun_pkg::BYTE_W-1:0] bit_mask;
  logic [brun_pkg::BYTE_W-1:0] wr_byte;
  logic [brun_pkg::BYTE_W-1:0] rdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [brun_pkg::BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [31:0]                 start_calc;

  // managed byte count, clamped to 1..MAX_BYTES
  always_comb begin
    int unsigned n;
    logic [31:0] total;
    n = 32'(bytes_in_use);
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_BYTES) begin
      n = MAX_BYTES;
    end
    last   = PW'(n - 1);
    total  = n * 32'(brun_pkg::BYTE_W);
    reject = (len_r == '0) || (32'(len_r) > total);
  end

  assign idx_out  = 32'(idx_r[brun_pkg::IDX_W-1:brun_pkg::SEL_W]) >= 32'(MAX_BYTES);
  assign idx_addr = AW'(idx_r[brun_pkg::IDX_W-1:brun_pkg::SEL_W]);
  assign bit_mask = brun_pkg::BYTE_W'(1) << idx_r[brun_pkg::SEL_W-1:0];
  assign wr_byte  = val_r ? (rdata | bit_mask) : (rdata & ~bit_mask);

  assign ram_we    = ctl.sweep || (ctl.bit_wr && !idx_out);
  assign ram_waddr = ctl.sweep ? ptr[AW-1:0] : idx_addr;
  assign ram_wdata = ctl.sweep ? '0 : wr_byte;
  assign ram_raddr = ctl.bit_rd ? idx_addr : ptr[AW-1:0];

  brun_ram #(
    .WIDTH (brun_pkg::BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // run counting over the eight bits of one byte, LSB first
  always_comb begin
    count_next = count;
    hit        = 1'b0;
    hit_bit    = '0;
    for (int k = 0; k < brun_pkg::BYTE_W; k++) begin
      if (!hit) begin
        if (!rdata[k]) begin
          count_next = count_next + 1'b1;
          if (count_next == len_r) begin
            hit     = 1'b1;
            hit_bit = brun_pkg::SEL_W'(k);
          end
        end else begin
          count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= brun_pkg::CFG_RESET;
    end else if (cfg_we) begin
      bytes_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      proc_valid <= 1'b0;
      scan_fin   <= 1'b0;
    end else if (ctl.load) begin
      ptr        <= '0;
      proc_valid <= 1'b0;
      scan_fin   <= 1'b0;
    end else begin
      if (ctl.sweep || ctl.scan_rd) begin
        ptr <= ptr + 1'b1;
      end
      proc_valid <= ctl.scan_rd && (ptr <= last);
      if (proc_valid && !scan_fin && (hit || (proc_addr == last[AW-1:0]))) begin
        scan_fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_addr <= ptr[AW-1:0];
    if (ctl.load) begin
      idx_r   <= in_bit_index;
      len_r   <= in_run_length;
      val_r   <= in_bit_value;
      count   <= '0;
      found_r <= 1'b0;
      state_r <= 1'b0;
    end else begin
      if (proc_valid && !scan_fin) begin
        count <= count_next;
        if (hit) begin
          found_r <= 1'b1;
          hit_pos <= {proc_addr, hit_bit};
        end
      end
      if (ctl.test_latch) begin
        state_r <= !idx_out && rdata[idx_r[brun_pkg::SEL_W-1:0]];
      end
    end
  end

  assign start_calc = 32'(hit_pos) + 32'd1 - 32'(len_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result) begin
      out_found       <= found_r;
      out_start_index <= found_r ? start_calc[brun_pkg::IDX_W-1:0] : '0;
      out_bit_state   <= state_r;
    end
  end

  assign sts = '{
    sweep_last: (ptr == (ctl.sweep_all ? ALL_LAST : last)),
    scan_fin:   scan_fin,
    reject:     reject,
    out_free:   (!out_valid || out_ready)
  };

`ifndef SYNTH
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.sweep, ctl.scan_rd, ctl.bit_rd, ctl.bit_wr, ctl.test_latch, ctl.result}))
    else $error("datapath commands overlap");

  a_no_found_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_start_index == '0)
    else $error("start index set without a found run");

  a_found_no_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_found |-> !out_bit_state)
    else $error("scan result carries a bit state");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    ctl.result |-> !out_valid || out_ready)
    else $error("result loaded over an untaken one");
`endif

endmodule

// ===== src/bitmap_run_allocator.sv =====
// Bitmap run allocator: keeps a bitmap of MAX_BYTES bytes, one bit per unit
// (0 free, 1 used), bit 0 being the LSB of byte 0.
// cmd channel (valid/ready): func selects clear, test bit, scan for run, or
// write bit. rsp channel (valid/ready): one transfer per command with found,
// start_index and bit_state.
// cfg_we/cfg_wdata write bytes_in_use (reset 128), the number of bytes that
// clear and scan cover; write it only while no command is in flight.
// One command is worked at a time. Test reads the byte and latches the bit;
// write reads the byte and writes it back with the bit changed; clear zeroes
// the managed bytes; scan reads one bitmap byte per cycle through the single
// RAM read port, and a run that cannot fit ends the scan with no read.
// cmd.ready returns in the same cycle the result appears on rsp.
// A held rsp (rsp.ready low) keeps the result; the next command is taken and
// worked but its result waits until the register is free.
// Reset (rst, synchronous) starts a clearing pass that zeroes the whole
// bitmap, one byte per cycle; cmd.ready stays low meanwhile.
module bitmap_run_allocator #(
  parameter int MAX_BYTES = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  brun_cmd_if.sink                   cmd,
  brun_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [brun_pkg::CFG_W-1:0] cfg_wdata
);

  brun_pkg::ctl_cmd_t ctl;
  brun_pkg::dp_sts_t  sts;

  brun_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_func  (cmd.func),
    .in_ready (cmd.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  brun_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_bit_index    (cmd.bit_index),
    .in_run_length   (cmd.run_length),
    .in_bit_value    (cmd.bit_value),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_found       (rsp.found),
    .out_start_index (rsp.start_index),
    .out_bit_state   (rsp.bit_state)
  );

endmodule

// ===== dv/tb_bitmap_run_allocator.sv =====
module tb_bitmap_run_allocator;

  localparam int STORE_BYTES = 128;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int NUM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 61;
  localparam int MAX_REPORTS = 10;
  localparam logic [brun_pkg::CFG_W-1:0] PHASE_CFG [NUM_PHASES] =
    '{8'd1, 8'd3, 8'd128, 8'd0, 8'd16, 8'd200, 8'd8, 8'd255, 8'd64};

  typedef struct packed {
    brun_pkg::func_t            func;
    logic [brun_pkg::IDX_W-1:0] bit_index;
    logic [brun_pkg::LEN_W-1:0] run_length;
    logic                       bit_value;
  } alloc_cmd_t;

  typedef struct packed {
    logic                       found;
    logic [brun_pkg::IDX_W-1:0] start_index;
    logic                       bit_state;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [brun_pkg::CFG_W-1:0] cfg_wdata;

  brun_cmd_if cmd_bus ();
  brun_rsp_if rsp_bus ();

  bitmap_run_allocator #(
    .MAX_BYTES(STORE_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [brun_pkg::BYTE_W-1:0] bitmap_img [STORE_BYTES];
  logic [brun_pkg::CFG_W-1:0] bytes_in_use;
  alloc_cmd_t cmd_backlog [$];
  alloc_rsp_t rsp_due_q [$];
  alloc_cmd_t cmd_held;
  alloc_rsp_t rsp_got;
  alloc_rsp_t rsp_want;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int cmds_queued = 0;
  int cmds_accepted = 0;
  int mismatches = 0;
  int rsp_count = 0;
  int scans_hit = 0;
  int scans_miss = 0;
  int cfg_writes = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int managed_bytes(logic [brun_pkg::CFG_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > STORE_BYTES) return STORE_BYTES;
    return int'(cfg);
  endfunction

  // Updates the bitmap image and returns the response the command must produce.
  function automatic alloc_rsp_t predict_bitmap_result(alloc_cmd_t c);
    alloc_rsp_t r;
    int total;
    int run;
    int byte_at;
    r = '0;
    byte_at = int'(c.bit_index) >> 3;
    case (c.func)
      brun_pkg::FUNC_CLEAR: begin
        for (int b = 0; b < managed_bytes(bytes_in_use); b++) bitmap_img[b] = '0;
      end
      brun_pkg::FUNC_TEST: begin
        if (byte_at < STORE_BYTES) r.bit_state = bitmap_img[byte_at][c.bit_index[2:0]];
      end
      brun_pkg::FUNC_SCAN: begin
        total = managed_bytes(bytes_in_use) * 8;
        run = 0;
        if (c.run_length != 0 && c.run_length <= total) begin
          for (int i = 0; i < total; i++) begin
            if (bitmap_img[i / 8][i % 8] == 1'b0) begin
              run++;
              if (run == c.run_length) begin
                r.found = 1'b1;
                r.start_index = brun_pkg::IDX_W'(i + 1 - run);
                break;
              end
            end else begin
              run = 0;
            end
          end
        end
        if (r.found) scans_hit++;
        else scans_miss++;
      end
      default: begin
        if (byte_at < STORE_BYTES) bitmap_img[byte_at][c.bit_index[2:0]] = c.bit_value;
      end
    endcase
    return r;
  endfunction

  // Writes cluster near the bottom of the managed range so scans see fragmentation.
  function automatic alloc_cmd_t random_cmd(int nbits);
    alloc_cmd_t c;
    int pick;
    c.bit_index = brun_pkg::IDX_W'($urandom_range(1023));
    c.run_length = brun_pkg::LEN_W'($urandom_range(2047));
    c.bit_value = ($urandom_range(99) < 65);
    pick = $urandom_range(99);
    if (pick < 5) c.func = brun_pkg::FUNC_CLEAR;
    else if (pick < 30) c.func = brun_pkg::FUNC_TEST;
    else if (pick < 60) c.func = brun_pkg::FUNC_SCAN;
    else c.func = brun_pkg::FUNC_WRITE;
    pick = $urandom_range(99);
    if (c.func == brun_pkg::FUNC_TEST || c.func == brun_pkg::FUNC_WRITE) begin
      if (pick < 50)
        c.bit_index = brun_pkg::IDX_W'($urandom_range((nbits < 64 ? nbits : 64) - 1));
      else if (pick < 85) c.bit_index = brun_pkg::IDX_W'($urandom_range(nbits - 1));
    end else if (c.func == brun_pkg::FUNC_SCAN) begin
      if (pick < 8) c.run_length = '0;
      else if (pick < 55)
        c.run_length = brun_pkg::LEN_W'($urandom_range(nbits < 8 ? nbits : 8, 1));
      else if (pick < 80) c.run_length = brun_pkg::LEN_W'($urandom_range(nbits, 1));
      else if (pick < 92) c.run_length = brun_pkg::LEN_W'($urandom_range(nbits + 8, nbits));
    end
    return c;
  endfunction

  function automatic void queue_cmd(brun_pkg::func_t f, int idx, int len, logic v);
    alloc_cmd_t c;
    c.func = f;
    c.bit_index = brun_pkg::IDX_W'(idx);
    c.run_length = brun_pkg::LEN_W'(len);
    c.bit_value = v;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endfunction

  task automatic write_cfg(logic [brun_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bytes_in_use = v;
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (cmds_accepted != cmds_queued || rsp_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cmd driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        rsp_due_q.push_back(predict_bitmap_result(cmd_held));
        cmds_accepted++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cmd_held = cmd_backlog.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.func <= cmd_held.func;
          cmd_bus.bit_index <= cmd_held.bit_index;
          cmd_bus.run_length <= cmd_held.run_length;
          cmd_bus.bit_value <= cmd_held.bit_value;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // rsp monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_got = {rsp_bus.found, rsp_bus.start_index, rsp_bus.bit_state};
        rsp_count++;
        if (rsp_due_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("ERROR: unexpected rsp transfer found=%0b start=%0d bit=%0b",
                     rsp_got.found, rsp_got.start_index, rsp_got.bit_state);
          mismatches++;
        end else begin
          rsp_want = rsp_due_q.pop_front();
          if (rsp_got.found !== rsp_want.found ||
              rsp_got.start_index !== rsp_want.start_index ||
              rsp_got.bit_state !== rsp_want.bit_state) begin
            if (mismatches < MAX_REPORTS)
              $display({"ERROR: rsp %0d exp found=%0b start=%0d bit=%0b, ",
                        "got found=%0b start=%0d bit=%0b"},
                       rsp_count, rsp_want.found, rsp_want.start_index, rsp_want.bit_state,
                       rsp_got.found, rsp_got.start_index, rsp_got.bit_state);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d rsp outstanding", cycles, rsp_due_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    alloc_cmd_t c;
    int nbits;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.func = brun_pkg::FUNC_CLEAR;
    cmd_bus.bit_index = '0;
    cmd_bus.run_length = '0;
    cmd_bus.bit_value = 1'b0;
    rsp_bus.ready = 1'b0;
    bytes_in_use = brun_pkg::CFG_RESET;
    foreach (bitmap_img[b]) bitmap_img[b] = '0;
    send_gap_pct = 32;
    recv_stall_pct = 82;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map, end bits, run limits, clear
    queue_cmd(brun_pkg::FUNC_TEST, 0, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_TEST, 1023, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 1024, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 1025, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 1023, 2047, 1'b1);
    queue_cmd(brun_pkg::FUNC_WRITE, 0, 0, 1'b1);
    queue_cmd(brun_pkg::FUNC_WRITE, 1023, 2047, 1'b1);
    queue_cmd(brun_pkg::FUNC_TEST, 1023, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 1, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 1022, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 1023, 1'b0);
    queue_cmd(brun_pkg::FUNC_WRITE, 0, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_TEST, 0, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_WRITE, 0, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 1023, 1'b0);
    queue_cmd(brun_pkg::FUNC_CLEAR, 1023, 2047, 1'b1);
    queue_cmd(brun_pkg::FUNC_TEST, 1023, 0, 1'b0);
    queue_cmd(brun_pkg::FUNC_WRITE, 511, 0, 1'b1);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 600, 1'b0);
    queue_cmd(brun_pkg::FUNC_WRITE, 7, 0, 1'b1);
    queue_cmd(brun_pkg::FUNC_WRITE, 8, 0, 1'b1);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 8, 1'b0);
    queue_cmd(brun_pkg::FUNC_SCAN, 0, 2, 1'b0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_gap_pct = 32;
          recv_stall_pct = 82;
        end
        1: begin
          send_gap_pct = 82;
          recv_stall_pct = 32;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_cfg(PHASE_CFG[p]);
      nbits = managed_bytes(PHASE_CFG[p]) * 8;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        c = random_cmd(nbits);
        queue_cmd(c.func, c.bit_index, c.run_length, c.bit_value);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d commands and %0d rsp transfers across %0d bytes_in_use writes",
             cmds_accepted, rsp_count, cfg_writes);
    $display("Scans: %0d found a run, %0d found none; %0d mismatches",
             scans_hit, scans_miss, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
